// ===== src/lic_pkg.sv =====
// Package for the two-line intersection block: widths, packed word layouts
// and the structs passed out of the front end and the quotient pipelines.
// No dependencies.
package lic_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;
   localparam int OUT_BITS   = 48;

   localparam int DIFF_W = COORD_BITS + 1;
   localparam int PROD_W = DIFF_W + COORD_BITS;
   localparam int EQ_W   = PROD_W + 1;
   localparam int DET_W  = 2 * DIFF_W + 1;
   localparam int NUM_W  = EQ_W + DIFF_W + 1;
   localparam int N_W    = NUM_W + FRAC_BITS;
   localparam int HI_W   = N_W - OUT_BITS;

   localparam int FRONT_DEPTH = 5;
   localparam int DIV_DEPTH   = OUT_BITS + 3;
   localparam int PIPE_DEPTH  = FRONT_DEPTH + DIV_DEPTH;

   localparam int REQ_W = 8 * COORD_BITS;
   localparam int RSP_W = ((2 * OUT_BITS + 2 + 7) / 8) * 8;

   localparam logic [OUT_BITS-1:0] POS_LIMIT = {1'b0, {(OUT_BITS-1){1'b1}}};
   localparam logic [OUT_BITS-1:0] NEG_LIMIT = {1'b1, {(OUT_BITS-1){1'b0}}};

   typedef struct packed {
      logic signed [NUM_W-1:0] num_x;
      logic signed [NUM_W-1:0] num_y;
      logic signed [DET_W-1:0] det;
   } num_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] value;
      logic                       ovf;
      logic                       zero;
   } quot_type;

endpackage

// ===== src/lic_front.sv =====
// Front end of the intersection pipeline: line coefficients, determinant
// and the two Cramer numerators over five register stages.
// Depends on lic_pkg.
module lic_front (
   input  logic                            clock,
   input  logic                            en,
   input  logic [lic_pkg::REQ_W-1:0]       word,
   output lic_pkg::num_type                nums
);

   localparam int CB = lic_pkg::COORD_BITS;

   logic signed [CB-1:0] xa0, ya0, xa1, ya1, xb0, yb0, xb1, yb1;

   logic signed [lic_pkg::DIFF_W-1:0] a1_ff, b1_ff, c1_ff, d1_ff;
   logic signed [CB-1:0]              xa_ff, ya_ff, xb_ff, yb_ff;

   logic signed [lic_pkg::DIFF_W-1:0] a2_ff, b2_ff, c2_ff, d2_ff;
   logic signed [lic_pkg::PROD_W-1:0] ax_ff, by_ff, cx_ff, dy_ff;
   logic signed [lic_pkg::DET_W-1:0]  ad_ff, bc_ff;

   logic signed [lic_pkg::DIFF_W-1:0] a3_ff, b3_ff, c3_ff, d3_ff;
   logic signed [lic_pkg::EQ_W-1:0]   e3_ff, f3_ff;
   logic signed [lic_pkg::DET_W-1:0]  det3_ff;

   logic signed [lic_pkg::NUM_W-2:0]  ed_ff, bf_ff, af_ff, ec_ff;
   logic signed [lic_pkg::DET_W-1:0]  det4_ff;

   logic signed [lic_pkg::NUM_W-1:0]  nx_ff, ny_ff;
   logic signed [lic_pkg::DET_W-1:0]  det5_ff;

   assign xa0 = word[0*CB +: CB];
   assign ya0 = word[1*CB +: CB];
   assign xa1 = word[2*CB +: CB];
   assign ya1 = word[3*CB +: CB];
   assign xb0 = word[4*CB +: CB];
   assign yb0 = word[5*CB +: CB];
   assign xb1 = word[6*CB +: CB];
   assign yb1 = word[7*CB +: CB];

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff <= lic_pkg::DIFF_W'(ya0) - lic_pkg::DIFF_W'(ya1);
         b1_ff <= lic_pkg::DIFF_W'(xa1) - lic_pkg::DIFF_W'(xa0);
         c1_ff <= lic_pkg::DIFF_W'(yb0) - lic_pkg::DIFF_W'(yb1);
         d1_ff <= lic_pkg::DIFF_W'(xb1) - lic_pkg::DIFF_W'(xb0);
         xa_ff <= xa0;
         ya_ff <= ya0;
         xb_ff <= xb0;
         yb_ff <= yb0;

         a2_ff <= a1_ff;
         b2_ff <= b1_ff;
         c2_ff <= c1_ff;
         d2_ff <= d1_ff;
         ax_ff <= lic_pkg::PROD_W'(a1_ff) * lic_pkg::PROD_W'(xa_ff);
         by_ff <= lic_pkg::PROD_W'(b1_ff) * lic_pkg::PROD_W'(ya_ff);
         cx_ff <= lic_pkg::PROD_W'(c1_ff) * lic_pkg::PROD_W'(xb_ff);
         dy_ff <= lic_pkg::PROD_W'(d1_ff) * lic_pkg::PROD_W'(yb_ff);
         ad_ff <= lic_pkg::DET_W'(a1_ff) * lic_pkg::DET_W'(d1_ff);
         bc_ff <= lic_pkg::DET_W'(b1_ff) * lic_pkg::DET_W'(c1_ff);

         a3_ff   <= a2_ff;
         b3_ff   <= b2_ff;
         c3_ff   <= c2_ff;
         d3_ff   <= d2_ff;
         e3_ff   <= lic_pkg::EQ_W'(ax_ff) + lic_pkg::EQ_W'(by_ff);
         f3_ff   <= lic_pkg::EQ_W'(cx_ff) + lic_pkg::EQ_W'(dy_ff);
         det3_ff <= ad_ff - bc_ff;

         ed_ff   <= (lic_pkg::NUM_W-1)'(e3_ff) * (lic_pkg::NUM_W-1)'(d3_ff);
         bf_ff   <= (lic_pkg::NUM_W-1)'(b3_ff) * (lic_pkg::NUM_W-1)'(f3_ff);
         af_ff   <= (lic_pkg::NUM_W-1)'(a3_ff) * (lic_pkg::NUM_W-1)'(f3_ff);
         ec_ff   <= (lic_pkg::NUM_W-1)'(e3_ff) * (lic_pkg::NUM_W-1)'(c3_ff);
         det4_ff <= det3_ff;

         nx_ff   <= lic_pkg::NUM_W'(ed_ff) - lic_pkg::NUM_W'(bf_ff);
         ny_ff   <= lic_pkg::NUM_W'(af_ff) - lic_pkg::NUM_W'(ec_ff);
         det5_ff <= det4_ff;
      end
   end

   assign nums.num_x = nx_ff;
   assign nums.num_y = ny_ff;
   assign nums.det   = det5_ff;

endmodule

// ===== src/lic_div.sv =====
// Pipelined restoring divider: (num * 2^FRAC_BITS) / det, truncated toward
// zero and saturated, one quotient bit per stage. Depends on lic_pkg.
module lic_div (
   input  logic                             clock,
   input  logic                             en,
   input  logic signed [lic_pkg::NUM_W-1:0] num,
   input  logic signed [lic_pkg::DET_W-1:0] det,
   output lic_pkg::quot_type                quot
);

   localparam int OB = lic_pkg::OUT_BITS;
   localparam int DW = lic_pkg::DET_W;

   logic [lic_pkg::NUM_W-1:0] mag_ff;
   logic [DW-1:0]             dvp_ff;
   logic                      negp_ff;

   logic [lic_pkg::N_W-1:0]   shifted;

   logic [DW-1:0] rem_ff [0:OB];
   logic [OB-1:0] low_ff [0:OB];
   logic [OB-1:0] q_ff   [0:OB];
   logic [DW-1:0] dv_ff  [0:OB];
   logic          neg_ff [0:OB];
   logic          big_ff [0:OB];

   logic [OB-1:0] limit, qmag;
   logic          ovf;
   lic_pkg::quot_type quot_ff, quot_in;

   assign shifted = {mag_ff, {lic_pkg::FRAC_BITS{1'b0}}};

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff  <= num[lic_pkg::NUM_W-1] ? lic_pkg::NUM_W'(-num) : lic_pkg::NUM_W'(num);
         dvp_ff  <= det[DW-1] ? DW'(-det) : DW'(det);
         negp_ff <= num[lic_pkg::NUM_W-1] ^ det[DW-1];

         big_ff[0] <= DW'(shifted[lic_pkg::N_W-1 -: lic_pkg::HI_W]) >= dvp_ff;
         rem_ff[0] <= DW'(shifted[lic_pkg::N_W-1 -: lic_pkg::HI_W]);
         low_ff[0] <= shifted[OB-1:0];
         q_ff[0]   <= '0;
         dv_ff[0]  <= dvp_ff;
         neg_ff[0] <= negp_ff;
      end
   end

   for (genvar k = 0; k < OB; k++) begin : g_step
      logic [DW:0]   trial;
      logic          fits;
      logic [DW-1:0] rem_in;

      assign trial  = {rem_ff[k], low_ff[k][OB-1-k]};
      assign fits   = trial >= {1'b0, dv_ff[k]};
      assign rem_in = fits ? DW'(trial - {1'b0, dv_ff[k]}) : trial[DW-1:0];

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= rem_in;
            low_ff[k+1] <= low_ff[k];
            q_ff[k+1]   <= {q_ff[k][OB-2:0], fits};
            dv_ff[k+1]  <= dv_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            big_ff[k+1] <= big_ff[k];
         end
      end
   end

   always_comb begin
      limit = neg_ff[OB] ? lic_pkg::NEG_LIMIT : lic_pkg::POS_LIMIT;
      ovf   = big_ff[OB] || (q_ff[OB] > limit);
      qmag  = ovf ? limit : q_ff[OB];
      quot_in.value = neg_ff[OB] ? -qmag : qmag;
      quot_in.ovf   = ovf;
      quot_in.zero  = (dv_ff[OB] == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule

// ===== src/line_intersection_cramer.sv =====
// Two-line intersection by Cramer's rule, Q32.16 result with saturation.
// rsp_tvalid rises after a req word passes lic_front, lic_div and the output register.
// Throughput: one word per cycle; the whole pipeline advances together
// whenever the output register is empty or being taken.
// Reset clears all valid bits; data registers are not reset.
// Depends on lic_pkg, lic_front and lic_div.
module line_intersection_cramer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
   // seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y (16 bits each)
   input  logic [lic_pkg::REQ_W-1:0]    req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // solvable[0], cross_x[48:1], cross_y[96:49], overflow[97], zero pad
   output logic [lic_pkg::RSP_W-1:0]    rsp_tdata
);

   localparam int OB = lic_pkg::OUT_BITS;

   logic en;
   logic [lic_pkg::PIPE_DEPTH-1:0] vld_ff, vld_in;
   logic                           rsp_tvalid_ff;
   logic [lic_pkg::RSP_W-1:0]      rsp_tdata_ff, rsp_tdata_in;

   lic_pkg::num_type  nums;
   lic_pkg::quot_type qx, qy;
   logic              solv;

   assign en = !rsp_tvalid_ff || rsp_tready;

   lic_front u_front (
      .clock (clock),
      .en    (en),
      .word  (req_tdata),
      .nums  (nums)
   );

   lic_div u_div_x (
      .clock (clock),
      .en    (en),
      .num   (nums.num_x),
      .det   (nums.det),
      .quot  (qx)
   );

   lic_div u_div_y (
      .clock (clock),
      .en    (en),
      .num   (nums.num_y),
      .det   (nums.det),
      .quot  (qy)
   );

   always_comb begin
      solv = !qx.zero;
      vld_in = {vld_ff[lic_pkg::PIPE_DEPTH-2:0], req_tvalid};
      rsp_tdata_in = '0;
      rsp_tdata_in[0]            = solv;
      rsp_tdata_in[1 +: OB]      = solv ? qx.value : '0;
      rsp_tdata_in[1 + OB +: OB] = solv ? qy.value : '0;
      rsp_tdata_in[1 + 2 * OB]   = solv && (qx.ovf || qy.ovf);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         vld_ff        <= vld_in;
         rsp_tvalid_ff <= vld_ff[lic_pkg::PIPE_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign req_tready = en;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_zero_unsolvable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && !rsp_tdata_ff[0] |-> rsp_tdata_ff[2*OB:1] == '0
         && !rsp_tdata_ff[1 + 2 * OB])
      else $error("unsolvable word carries nonzero payload");

   a_ovf_solvable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_tdata_ff[1 + 2 * OB] |-> rsp_tdata_ff[0])
      else $error("overflow flagged on unsolvable word");

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("valid pipeline moved during stall");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      en && vld_ff[lic_pkg::PIPE_DEPTH-1] |=> rsp_tvalid_ff)
      else $error("finished word lost at output register");

endmodule
